[hw/rtl/aosr_pkg.sv]
// Shared types, constants and the exponent table of the online softmax attention row unit.
package aosr_pkg;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_HEAD_DIM = 16;
   localparam int LANES        = 16;

   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [16:0] ONE_Q16    = 17'h10000;
   localparam logic [17:0] LOG2E_FRAC = 18'd29012;
   localparam logic [17:0] EXP_CUTOFF = 18'd17;

   localparam logic [1:0] CSR_ROWS_IN_USE = 2'd0;
   localparam logic [1:0] CSR_SCORE_SCALE = 2'd1;

   typedef enum logic [1:0] {
      MODE_LOAD_Q  = 2'd0,
      MODE_LOAD_K  = 2'd1,
      MODE_LOAD_V  = 2'd2,
      MODE_COMPUTE = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic [5:0]         row;
      logic [3:0]         dim;
      logic signed [15:0] element_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_value;
      logic [5:0]         out_row;
      logic [3:0]         out_dim;
      logic               last;
   } rsp_type;

   function automatic logic [16:0] pow2_lut(input logic [5:0] idx);
      logic [16:0] v;
      case (idx)
         6'd0:  v = 17'd65536;
         6'd1:  v = 17'd64132;
         6'd2:  v = 17'd62757;
         6'd3:  v = 17'd61413;
         6'd4:  v = 17'd60097;
         6'd5:  v = 17'd58809;
         6'd6:  v = 17'd57549;
         6'd7:  v = 17'd56316;
         6'd8:  v = 17'd55109;
         6'd9:  v = 17'd53928;
         6'd10: v = 17'd52773;
         6'd11: v = 17'd51642;
         6'd12: v = 17'd50535;
         6'd13: v = 17'd49452;
         6'd14: v = 17'd48393;
         6'd15: v = 17'd47356;
         6'd16: v = 17'd46341;
         6'd17: v = 17'd45348;
         6'd18: v = 17'd44376;
         6'd19: v = 17'd43425;
         6'd20: v = 17'd42495;
         6'd21: v = 17'd41584;
         6'd22: v = 17'd40693;
         6'd23: v = 17'd39821;
         6'd24: v = 17'd38968;
         6'd25: v = 17'd38133;
         6'd26: v = 17'd37316;
         6'd27: v = 17'd36516;
         6'd28: v = 17'd35734;
         6'd29: v = 17'd34968;
         6'd30: v = 17'd34219;
         6'd31: v = 17'd33486;
         6'd32: v = 17'd32768;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/aosr_mul.sv]
// Shared signed multiplier with a registered product.
module aosr_mul (
   input  logic                                 clock,
   input  logic signed [aosr_pkg::MUL_A_W-1:0]  mul_a,
   input  logic signed [aosr_pkg::MUL_B_W-1:0]  mul_b,
   output logic signed [aosr_pkg::MUL_P_W-1:0]  prod_ff
);
   import aosr_pkg::*;

   logic signed [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[hw/rtl/attention_online_softmax_row_unit.sv]
// Top level of the online softmax attention row unit: stores, sequencer, divider and ports.
//
// Load transactions write one Q8.8 element into the query, key or value store. A compute
// transaction walks the key rows through one shared 25x18 multiplier under a small
// sequencer: each key row passes through the dot product, scaling, the exponent (not for
// the first row), the running sum and the accumulator update of each lane in turn; then
// the HEAD_DIM outputs come from a restoring divider, one lane at a time. The unit takes
// no new transaction during a compute; the last output may still wait in the output
// register while the next transaction is accepted.
module attention_online_softmax_row_unit #(
   parameter int MAX_ROWS = aosr_pkg::DEF_MAX_ROWS,
   parameter int HEAD_DIM = aosr_pkg::DEF_HEAD_DIM
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  aosr_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output aosr_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import aosr_pkg::*;

   localparam int DEPTH  = MAX_ROWS * LANES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [6:0] ROWS_CAP = (MAX_ROWS > 127) ? 7'd127 : 7'(MAX_ROWS);

   typedef enum logic [20:0] {
      ST_IDLE     = 21'h000001,
      ST_DOT      = 21'h000002,
      ST_SC_HI    = 21'h000004,
      ST_SC_LO    = 21'h000008,
      ST_SC_SUM   = 21'h000010,
      ST_CMP      = 21'h000020,
      ST_EX_HI    = 21'h000040,
      ST_EX_LO    = 21'h000080,
      ST_EX_T     = 21'h000100,
      ST_EX_INT   = 21'h000200,
      ST_EX_VAL   = 21'h000400,
      ST_SU_HI    = 21'h000800,
      ST_SU_LO    = 21'h001000,
      ST_SU_ADD   = 21'h002000,
      ST_LN_HI    = 21'h004000,
      ST_LN_LO    = 21'h008000,
      ST_LN_VW    = 21'h010000,
      ST_LN_ADD   = 21'h020000,
      ST_DIV_INIT = 21'h040000,
      ST_DIV_STEP = 21'h080000,
      ST_EMIT     = 21'h100000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] query_mem [DEPTH];
   logic [15:0] key_mem   [DEPTH];
   logic [15:0] value_mem [DEPTH];
   logic signed [15:0] q_rd_ff, k_rd_ff, v_rd_ff;

   logic [6:0]  rows_ff, rows_in;
   logic [15:0] scale_ff, scale_in;
   logic [5:0]  row_ff, row_in;
   logic [6:0]  j_ff, j_in, nrows_ff, nrows_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [3:0]  d_ff, d_in;
   logic        rd_v_ff, rd_v_in, pr_v_ff, pr_v_in;
   logic        first_ff, first_in, to_alpha_ff, to_alpha_in;
   logic signed [35:0] dot_ff, dot_in;
   logic signed [47:0] score_ff, score_in;
   logic signed [31:0] max_ff, max_in;
   logic [31:0] x_ff, x_in;
   logic [33:0] t_ff, t_in;
   logic [16:0] alpha_ff, alpha_in, w_ff, w_in;
   logic [31:0] sum_ff, sum_in;
   logic signed [47:0] tmp_ff, tmp_in;
   logic signed [39:0] acc_ff [LANES];
   logic signed [39:0] acc_in [LANES];
   logic [39:0] rem_ff, rem_in;
   logic [48:0] dsh_ff, dsh_in;
   logic [16:0] q_ff, q_in;
   logic [4:0]  step_ff, step_in;
   logic        neg_ff, neg_in, ovf_ff, ovf_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod_ff;

   logic        accept, row_ok, dim_ok, is_load;
   logic [6:0]  nrows_eff;
   logic [15:0] wr_full, q_full, k_full, v_full;
   logic [ADDR_W-1:0] wr_addr, q_addr, k_addr, v_addr;
   logic signed [31:0] s_sat;
   logic        s_fits, issuing, lane_last, can_load;
   logic [16:0] tab_a, tab_b, tab_diff, exp_base, exp_val;
   logic [5:0]  tab_idx;
   logic signed [39:0] acc_sel;
   logic [39:0] acc_mag;
   logic [31:0] den;
   logic signed [47:0] su_sum, ln_sum;
   logic [16:0] neg_q;
   logic [15:0] out_val;

   aosr_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign row_ok  = 32'(req_payload.row) < 32'(MAX_ROWS);
   assign dim_ok  = 32'(req_payload.dim) < 32'(HEAD_DIM);
   assign is_load = req_payload.mode != MODE_COMPUTE;
   assign nrows_eff = (rows_ff == 7'd0) ? 7'd1 : ((rows_ff > ROWS_CAP) ? ROWS_CAP : rows_ff);

   assign wr_full = {6'b0, req_payload.row, req_payload.dim};
   assign q_full  = {6'b0, row_ff, cnt_ff[3:0]};
   assign k_full  = {5'b0, j_ff, cnt_ff[3:0]};
   assign v_full  = {5'b0, j_ff, d_ff};
   assign wr_addr = wr_full[ADDR_W-1:0];
   assign q_addr  = q_full[ADDR_W-1:0];
   assign k_addr  = k_full[ADDR_W-1:0];
   assign v_addr  = v_full[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (accept && is_load && row_ok && dim_ok) begin
         unique case (req_payload.mode)
            MODE_LOAD_Q: query_mem[wr_addr] <= req_payload.element_value;
            MODE_LOAD_K: key_mem[wr_addr]   <= req_payload.element_value;
            MODE_LOAD_V: value_mem[wr_addr] <= req_payload.element_value;
            default: ;
         endcase
      end
      q_rd_ff <= query_mem[q_addr];
      k_rd_ff <= key_mem[k_addr];
      v_rd_ff <= value_mem[v_addr];
   end

   assign s_fits = score_ff[47:31] == {17{score_ff[31]}};
   assign s_sat  = s_fits ? score_ff[31:0] :
                   (score_ff[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

   assign issuing   = 32'(cnt_ff) < 32'(HEAD_DIM);
   assign lane_last = d_ff == 4'(HEAD_DIM - 1);
   assign can_load  = !rsp_valid_ff || rsp_ready;

   assign tab_idx  = {1'b0, t_ff[15:11]};
   assign tab_a    = pow2_lut(tab_idx);
   assign tab_b    = pow2_lut(tab_idx + 6'd1);
   assign tab_diff = tab_a - tab_b;
   assign exp_base = tab_a - prod_ff[27:11];
   assign exp_val  = (t_ff[33:16] >= EXP_CUTOFF) ? 17'd0 : (exp_base >> t_ff[20:16]);

   assign acc_sel = acc_ff[d_ff];
   assign acc_mag = acc_sel[39] ? 40'(-acc_sel) : acc_sel;
   assign den     = (sum_ff == 32'd0) ? 32'd1 : sum_ff;

   assign su_sum = tmp_ff + $signed({21'b0, prod_ff[42:16]}) + $signed({31'b0, w_ff});
   assign ln_sum = tmp_ff + 48'(prod_ff);

   assign neg_q = 17'd0 - q_ff;
   always_comb begin
      if (ovf_ff) begin
         out_val = neg_ff ? 16'h8000 : 16'h7FFF;
      end else if (!neg_ff) begin
         out_val = (q_ff > 17'd32767) ? 16'h7FFF : q_ff[15:0];
      end else begin
         out_val = (q_ff > 17'd32768) ? 16'h8000 : neg_q[15:0];
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_DOT: begin
            mul_a = MUL_A_W'(q_rd_ff);
            mul_b = MUL_B_W'(k_rd_ff);
         end
         ST_SC_HI: begin
            mul_a = MUL_A_W'($signed(dot_ff[35:16]));
            mul_b = {2'b0, scale_ff};
         end
         ST_SC_LO: begin
            mul_a = {9'b0, dot_ff[15:0]};
            mul_b = {2'b0, scale_ff};
         end
         ST_EX_HI: begin
            mul_a = {9'b0, x_ff[31:16]};
            mul_b = LOG2E_FRAC;
         end
         ST_EX_LO: begin
            mul_a = {9'b0, x_ff[15:0]};
            mul_b = LOG2E_FRAC;
         end
         ST_EX_INT: begin
            mul_a = {8'b0, tab_diff};
            mul_b = {7'b0, t_ff[10:0]};
         end
         ST_SU_HI: begin
            mul_a = {9'b0, sum_ff[31:16]};
            mul_b = {1'b0, alpha_ff};
         end
         ST_SU_LO: begin
            mul_a = {9'b0, sum_ff[15:0]};
            mul_b = {1'b0, alpha_ff};
         end
         ST_LN_HI: begin
            mul_a = MUL_A_W'($signed(acc_sel[39:16]));
            mul_b = {1'b0, alpha_ff};
         end
         ST_LN_LO: begin
            mul_a = {9'b0, acc_sel[15:0]};
            mul_b = {1'b0, alpha_ff};
         end
         ST_LN_VW: begin
            mul_a = MUL_A_W'(v_rd_ff);
            mul_b = {1'b0, w_ff};
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      rows_in     = rows_ff;
      scale_in    = scale_ff;
      row_in      = row_ff;
      j_in        = j_ff;
      nrows_in    = nrows_ff;
      cnt_in      = cnt_ff;
      d_in        = d_ff;
      rd_v_in     = rd_v_ff;
      pr_v_in     = pr_v_ff;
      first_in    = first_ff;
      to_alpha_in = to_alpha_ff;
      dot_in      = dot_ff;
      score_in    = score_ff;
      max_in      = max_ff;
      x_in        = x_ff;
      t_in        = t_ff;
      alpha_in    = alpha_ff;
      w_in        = w_ff;
      sum_in      = sum_ff;
      tmp_in      = tmp_ff;
      acc_in      = acc_ff;
      rem_in      = rem_ff;
      dsh_in      = dsh_ff;
      q_in        = q_ff;
      step_in     = step_ff;
      neg_in      = neg_ff;
      ovf_in      = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_IN_USE: rows_in  = csr_wdata[6:0];
            CSR_SCORE_SCALE: scale_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !is_load && row_ok) begin
               row_in   = req_payload.row;
               j_in     = 7'd0;
               nrows_in = nrows_eff;
               first_in = 1'b1;
               cnt_in   = 5'd0;
               dot_in   = '0;
               rd_v_in  = 1'b0;
               pr_v_in  = 1'b0;
               state_in = ST_DOT;
            end
         end
         ST_DOT: begin
            rd_v_in = issuing;
            pr_v_in = rd_v_ff;
            if (issuing) begin
               cnt_in = cnt_ff + 5'd1;
            end
            if (pr_v_ff) begin
               dot_in = dot_ff + 36'(prod_ff);
            end
            if (!issuing && !rd_v_ff && !pr_v_ff) begin
               state_in = ST_SC_HI;
            end
         end
         ST_SC_HI: state_in = ST_SC_LO;
         ST_SC_LO: begin
            score_in = 48'(prod_ff) <<< 8;
            state_in = ST_SC_SUM;
         end
         ST_SC_SUM: begin
            score_in = score_ff + $signed({13'b0, prod_ff[42:8]});
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (first_ff) begin
               max_in   = s_sat;
               alpha_in = 17'd0;
               w_in     = ONE_Q16;
               state_in = ST_SU_HI;
            end else if (s_sat > max_ff) begin
               x_in        = s_sat - max_ff;
               w_in        = ONE_Q16;
               to_alpha_in = 1'b1;
               max_in      = s_sat;
               state_in    = ST_EX_HI;
            end else begin
               x_in        = max_ff - s_sat;
               alpha_in    = ONE_Q16;
               to_alpha_in = 1'b0;
               state_in    = ST_EX_HI;
            end
         end
         ST_EX_HI: state_in = ST_EX_LO;
         ST_EX_LO: begin
            t_in     = {2'b0, x_ff} + prod_ff[33:0];
            state_in = ST_EX_T;
         end
         ST_EX_T: begin
            t_in     = t_ff + 34'(prod_ff[42:16]);
            state_in = ST_EX_INT;
         end
         ST_EX_INT: state_in = ST_EX_VAL;
         ST_EX_VAL: begin
            if (to_alpha_ff) begin
               alpha_in = exp_val;
            end else begin
               w_in = exp_val;
            end
            state_in = ST_SU_HI;
         end
         ST_SU_HI: state_in = ST_SU_LO;
         ST_SU_LO: begin
            tmp_in   = 48'(prod_ff);
            state_in = ST_SU_ADD;
         end
         ST_SU_ADD: begin
            sum_in   = first_ff ? {15'b0, w_ff} : su_sum[31:0];
            d_in     = 4'd0;
            state_in = ST_LN_HI;
         end
         ST_LN_HI: state_in = ST_LN_LO;
         ST_LN_LO: begin
            tmp_in   = first_ff ? 48'sd0 : 48'(prod_ff);
            state_in = ST_LN_VW;
         end
         ST_LN_VW: begin
            if (!first_ff) begin
               tmp_in = tmp_ff + $signed({21'b0, prod_ff[42:16]});
            end
            state_in = ST_LN_ADD;
         end
         ST_LN_ADD: begin
            acc_in[d_ff] = ln_sum[39:0];
            if (!lane_last) begin
               d_in     = d_ff + 4'd1;
               state_in = ST_LN_HI;
            end else if (j_ff + 7'd1 == nrows_ff) begin
               d_in     = 4'd0;
               state_in = ST_DIV_INIT;
            end else begin
               j_in     = j_ff + 7'd1;
               first_in = 1'b0;
               cnt_in   = 5'd0;
               dot_in   = '0;
               rd_v_in  = 1'b0;
               pr_v_in  = 1'b0;
               state_in = ST_DOT;
            end
         end
         ST_DIV_INIT: begin
            neg_in   = acc_sel[39];
            rem_in   = acc_mag;
            dsh_in   = {1'b0, den, 16'b0};
            ovf_in   = {9'b0, acc_mag} >= {den, 17'b0};
            q_in     = 17'd0;
            step_in  = 5'd0;
            state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            if ({9'b0, rem_ff} >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff[39:0];
               q_in   = {q_ff[15:0], 1'b1};
            end else begin
               q_in   = {q_ff[15:0], 1'b0};
            end
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd16) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (can_load) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_value = out_val;
               rsp_data_in.out_row   = row_ff;
               rsp_data_in.out_dim   = d_ff;
               rsp_data_in.last      = lane_last;
               if (lane_last) begin
                  state_in = ST_IDLE;
               end else begin
                  d_in     = d_ff + 4'd1;
                  state_in = ST_DIV_INIT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= 7'd64;
         scale_ff     <= 16'd64;
         max_ff       <= 32'sh8000_0000;
         sum_ff       <= 32'd0;
         rd_v_ff      <= 1'b0;
         pr_v_ff      <= 1'b0;
         alpha_ff     <= 17'd0;
         w_ff         <= 17'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rows_ff      <= rows_in;
         scale_ff     <= scale_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         rd_v_ff      <= rd_v_in;
         pr_v_ff      <= pr_v_in;
         alpha_ff     <= alpha_in;
         w_ff         <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      j_ff        <= j_in;
      nrows_ff    <= nrows_in;
      cnt_ff      <= cnt_in;
      d_ff        <= d_in;
      first_ff    <= first_in;
      to_alpha_ff <= to_alpha_in;
      dot_ff      <= dot_in;
      score_ff    <= score_in;
      x_ff        <= x_in;
      t_ff        <= t_in;
      tmp_ff      <= tmp_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      q_ff        <= q_in;
      step_ff     <= step_in;
      neg_ff      <= neg_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_sum_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_INIT) |-> (sum_ff >= 32'h10000))
      else $error("running sum below one at division");

   a_weights_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SU_HI) |-> (alpha_ff <= ONE_Q16 && w_ff <= ONE_Q16))
      else $error("softmax weight above one");

   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_load && row_ok) |=> !req_ready)
      else $error("compute transaction did not occupy the unit");

endmodule

[dv/testbench.sv]
// Testbench for the online softmax attention row unit: random loads and computes, scoreboard.
module testbench;
   import aosr_pkg::*;

   class softmax_scoreboard;
      logic signed [15:0] query_mem [1024];
      logic signed [15:0] key_mem [1024];
      logic signed [15:0] value_mem [1024];
      int unsigned rows_cfg = 64;
      int unsigned scale_cfg = 64;
      rsp_type expected_outputs [$];
      int errors = 0;
      int checked = 0;
      int computes = 0;
      int loads = 0;
      int unsigned pow2_table [33] = '{
         65536, 64132, 62757, 61413, 60097, 58809, 57549, 56316,
         55109, 53928, 52773, 51642, 50535, 49452, 48393, 47356,
         46341, 45348, 44376, 43425, 42495, 41584, 40693, 39821,
         38968, 38133, 37316, 36516, 35734, 34968, 34219, 33486,
         32768};

      function void write_register(logic [1:0] idx, logic [15:0] data);
         if (idx == CSR_ROWS_IN_USE) rows_cfg = data[6:0];
         else if (idx == CSR_SCORE_SCALE) scale_cfg = data;
      endfunction

      function longint exp_weight(bit [31:0] x);
         longint unsigned t;
         longint unsigned n;
         longint a;
         longint b;
         longint f;
         longint rem;
         longint idx;
         t = (longint'(x) * 94548) >> 16;
         n = t >> 16;
         f = t & 'hFFFF;
         idx = f >> 11;
         rem = f & 'h7FF;
         if (n >= 17) return 0;
         a = pow2_table[idx];
         b = pow2_table[idx + 1];
         return (a - (((a - b) * rem) >> 11)) >> n;
      endfunction

      function void note_request(req_type r);
         int nrows;
         longint dot;
         longint score;
         longint best;
         longint total;
         longint alpha;
         longint w;
         longint quotient;
         longint lane_acc [16];
         bit [31:0] diff;
         rsp_type o;
         int a;
         if (r.mode != MODE_COMPUTE) begin
            a = r.row * 16 + r.dim;
            loads++;
            case (r.mode)
               MODE_LOAD_Q: query_mem[a] = r.element_value;
               MODE_LOAD_K: key_mem[a] = r.element_value;
               default: value_mem[a] = r.element_value;
            endcase
            return;
         end
         computes++;
         nrows = (rows_cfg == 0) ? 1 : (rows_cfg > 64 ? 64 : rows_cfg);
         best = 0;
         total = 0;
         for (int j = 0; j < nrows; j++) begin
            dot = 0;
            for (int d = 0; d < 16; d++)
               dot += longint'(query_mem[r.row * 16 + d]) * longint'(key_mem[j * 16 + d]);
            score = (dot * longint'(scale_cfg)) >>> 8;
            if (score > 64'sd2147483647) score = 64'sd2147483647;
            if (score < -64'sd2147483648) score = -64'sd2147483648;
            if (j == 0) begin
               best = score;
               total = 65536;
               for (int d = 0; d < 16; d++) lane_acc[d] = longint'(value_mem[d]) * 65536;
               continue;
            end
            if (score > best) begin
               diff = score - best;
               alpha = exp_weight(diff);
               w = 65536;
               best = score;
            end else begin
               diff = best - score;
               alpha = 65536;
               w = exp_weight(diff);
            end
            total = (((total * alpha) >> 16) + w) & 64'hFFFF_FFFF;
            for (int d = 0; d < 16; d++)
               lane_acc[d] = ((lane_acc[d] * alpha) >>> 16)
                  + longint'(value_mem[j * 16 + d]) * w;
         end
         for (int d = 0; d < 16; d++) begin
            quotient = lane_acc[d] / (total != 0 ? total : 1);
            if (quotient > 32767) quotient = 32767;
            if (quotient < -32768) quotient = -32768;
            o.out_value = quotient[15:0];
            o.out_row = r.row;
            o.out_dim = d[3:0];
            o.last = (d == 15);
            expected_outputs.push_back(o);
         end
      endfunction

      function void check_result(rsp_type r);
         rsp_type e;
         if (expected_outputs.size() == 0) begin
            $error("unexpected output transaction %p", r);
            errors++;
            return;
         end
         e = expected_outputs.pop_front();
         checked++;
         if (r.out_value !== e.out_value) begin
            $error("out_value expected %0d actual %0d", e.out_value, r.out_value);
            errors++;
         end
         if (r.out_row !== e.out_row) begin
            $error("out_row expected %0d actual %0d", e.out_row, r.out_row);
            errors++;
         end
         if (r.out_dim !== e.out_dim) begin
            $error("out_dim expected %0d actual %0d", e.out_dim, r.out_dim);
            errors++;
         end
         if (r.last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, r.last);
            errors++;
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 40000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_payload;
   logic csr_wr_en = 0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   softmax_scoreboard board = new();
   bit idling = 1;
   bit hold_request = 0;
   int quiet_cycles = 0;

   attention_online_softmax_row_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata));

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_payload);
         if (rsp_valid && rsp_ready) board.check_result(rsp_payload);
      end
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("[attention_online_softmax_row_unit] ERROR");
         $finish;
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_ready <= 0;
            repeat (400) @(negedge clock);
         end else begin
            rsp_ready <= !idling || ($urandom_range(99) >= 6);
         end
      end
   end

   function automatic logic signed [15:0] pick_element();
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send(mode_type mode, int row, int dim, logic signed [15:0] value);
      int gap;
      gap = 0;
      if (idling && $urandom_range(99) < 6) gap = $urandom_range(1, 8);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_payload <= '{mode: mode, row: row[5:0], dim: dim[3:0], element_value: value};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_rows(int first, int count);
      for (int r = first; r < first + count; r++)
         for (int d = 0; d < 16; d++) begin
            send(MODE_LOAD_Q, r, d, pick_element());
            send(MODE_LOAD_K, r, d, pick_element());
            send(MODE_LOAD_V, r, d, pick_element());
         end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.expected_outputs.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] data);
      req_valid <= 0;
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 0;
      board.write_register(idx, data);
   endtask

   task automatic reconfigure(int rows, int scale);
      drain();
      write_csr(CSR_ROWS_IN_USE, rows[15:0]);
      write_csr(CSR_SCORE_SCALE, scale[15:0]);
   endtask

   task automatic random_item(int row_span);
      if ($urandom_range(99) < 70)
         send(mode_type'($urandom_range(2)), $urandom_range(row_span - 1),
              $urandom_range(15), pick_element());
      else
         send(MODE_COMPUTE, $urandom_range(row_span - 1), $urandom_range(15),
              16'($urandom));
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      load_rows(0, 2);
      write_csr(CSR_ROWS_IN_USE, 16'd1);
      write_csr(CSR_SCORE_SCALE, 16'hFFFF);
      send(MODE_LOAD_Q, 0, 0, 16'sh7FFF);
      send(MODE_LOAD_K, 0, 15, 16'sh8000);
      send(MODE_LOAD_V, 0, 0, 16'sh8000);
      send(MODE_LOAD_V, 0, 15, 16'sh7FFF);
      send(MODE_COMPUTE, 0, 15, 16'sh7FFF);
      reconfigure(0, 0);
      send(MODE_COMPUTE, 1, 0, 16'sh8000);
      reconfigure(2, 16'hFFFF);
      send(MODE_COMPUTE, 1, 0, 0);
      reconfigure(2, 0);
      send(MODE_COMPUTE, 0, 0, 0);
      reconfigure(2, 256);
      send(MODE_COMPUTE, 1, 0, 0);
      send(MODE_COMPUTE, 0, 0, 0);

      for (int phase = 0; phase < 3; phase++) begin
         reconfigure($urandom_range(0, 2),
                     ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 512));
         if (phase == 1) begin
            hold_request = 1;
            repeat (3) send(MODE_COMPUTE, $urandom_range(1), 0, 16'($urandom));
         end
         repeat (4) random_item(2);
      end

      idling = 0;
      reconfigure(2, 128);
      repeat (6) random_item(2);

      idling = 1;
      reconfigure(1, 200);
      repeat (4) random_item(2);

      drain();
      repeat (50) @(negedge clock);
      $display("Covered %0d loads and %0d compute rows, %0d outputs checked.",
               board.loads, board.computes, board.checked);
      $display("Configurations included zero, one and two rows and zero to full scale.");
      if (board.errors == 0 && board.expected_outputs.size() == 0) begin
         $display("[attention_online_softmax_row_unit] OK");
      end else begin
         $display("[attention_online_softmax_row_unit] ERROR");
      end
      $finish;
   end
endmodule
